@@ sv/f2p_pkg.sv @@
// Shared types and constants for the float-to-PCM sample converter.
`default_nettype none
package f2p_pkg;

	typedef enum logic [2:0] {
		FMT_FLOAT32     = 3'd0,
		FMT_PCM24_IN_32 = 3'd1,
		FMT_PCM32       = 3'd2,
		FMT_PCM24       = 3'd3,
		FMT_PCM16       = 3'd4
	} fmt_e;

	// full-scale class: unit means a pure power-of-two scale (2^31)
	typedef enum logic [1:0] {
		SCL_UNIT = 2'd0,
		SCL_16   = 2'd1,
		SCL_24   = 2'd2
	} scl_e;

	localparam logic [22:0] SCALE_16 = 23'd32767;
	localparam logic [22:0] SCALE_24 = 23'd8388607;
	localparam logic [7:0]  EXP_ONE  = 8'd127;
	localparam logic [7:0]  EXP_MAX  = 8'd255;
	localparam logic [9:0]  EXP_OFS  = 10'd150;
	localparam logic [9:0]  UNIT_SH  = 10'd31;

	typedef struct packed {
		logic [31:0] sample_bits;
		logic        last_sample;
	} req_t;

	typedef struct packed {
		logic [31:0] pcm_word;
		logic [2:0]  byte_count;
		logic        last_out;
	} res_t;

	typedef struct packed {
		logic [31:0] raw;
		logic [2:0]  fmt;
		logic        last;
		logic        sign;
		logic        zero;
	} meta_t;

	typedef struct packed {
		meta_t       meta;
		logic [23:0] mant;
		logic [7:0]  expb;
		scl_e        scl;
	} dec_t;

	typedef struct packed {
		meta_t       meta;
		logic [46:0] prod;
		logic [7:0]  expb;
		scl_e        scl;
	} mul_t;

	typedef struct packed {
		meta_t              meta;
		logic [24:0]        rnd;
		logic signed [9:0]  sh;
	} rnd_t;

endpackage
`default_nettype wire

@@ sv/float_to_pcm_sample_converter.sv @@
// Top level of the float-to-PCM sample converter.
`default_nettype none
// Converts one IEEE single-precision sample per cycle into the endpoint
// format held in the format register. Every request passes a four-stage
// pipeline (decode and clamp, multiply by full scale, round to nearest even,
// align and pack), so done rises from the last stage register, and a new
// request may be given every cycle. busy stays low. The receiver cannot
// stall: each result shows for one cycle with done. Write the format
// register only while no request is in flight.
module float_to_pcm_sample_converter (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_wr_en,
	input  wire logic [2:0]    cfg_wr_data,
	input  wire logic          start,
	output logic               busy,
	input  wire f2p_pkg::req_t req,
	output logic               done,
	output f2p_pkg::res_t      result
);
	logic [2:0]    fmt_q;
	logic          vld_s1;
	logic          vld_s2;
	logic          vld_s3;
	f2p_pkg::dec_t dec_s1;
	f2p_pkg::mul_t mul_s2;
	f2p_pkg::rnd_t rnd_s3;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= f2p_pkg::FMT_FLOAT32;
		end else if (cfg_wr_en) begin
			fmt_q <= cfg_wr_data;
		end
	end

	f2p_decode u_dec (
		.clk(clk), .arst_n(arst_n), .in_vld(start && !busy), .req(req),
		.fmt(fmt_q), .vld_s1(vld_s1), .dec_s1(dec_s1)
	);

	f2p_mul u_mul (
		.clk(clk), .arst_n(arst_n), .vld_s1(vld_s1), .dec_s1(dec_s1),
		.vld_s2(vld_s2), .mul_s2(mul_s2)
	);

	f2p_round u_rnd (
		.clk(clk), .arst_n(arst_n), .vld_s2(vld_s2), .mul_s2(mul_s2),
		.vld_s3(vld_s3), .rnd_s3(rnd_s3)
	);

	f2p_pack u_pack (
		.clk(clk), .arst_n(arst_n), .vld_s3(vld_s3), .rnd_s3(rnd_s3),
		.vld_s4(done), .res_s4(result)
	);

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |=> done) else $error("stage 3 request lost");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.byte_count == 3'd2 || result.byte_count == 3'd3 ||
			result.byte_count == 3'd4)) else $error("bad byte count");
	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && rnd_s3.meta.fmt == f2p_pkg::FMT_PCM32 && !rnd_s3.meta.sign)
		|=> !result.pcm_word[31])
		else $error("positive pcm32 went negative");
	a_s2: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |=> vld_s3) else $error("stage 2 request lost");
endmodule
`default_nettype wire

@@ sv/f2p_decode.sv @@
// Stage 1: unpack the float, clamp to unit range, pick the scale.
`default_nettype none
module f2p_decode (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_vld,
	input  wire f2p_pkg::req_t req,
	input  wire logic [2:0]    fmt,
	output logic               vld_s1,
	output f2p_pkg::dec_t      dec_s1
);
	logic [7:0]    e;
	logic [22:0]   frac;
	logic          nan;
	logic          big;
	f2p_pkg::dec_t d;

	always_comb begin
		e    = req.sample_bits[30:23];
		frac = req.sample_bits[22:0];
		nan  = (e == f2p_pkg::EXP_MAX) && (frac != 23'd0);
		big  = (e >= f2p_pkg::EXP_ONE);
		d.meta.raw  = req.sample_bits;
		d.meta.fmt  = fmt;
		d.meta.last = req.last_sample;
		d.meta.sign = req.sample_bits[31];
		// subnormals scale far below one LSB
		d.meta.zero = nan || (e == 8'd0);
		d.mant = big ? 24'h800000 : {1'b1, frac};
		d.expb = big ? f2p_pkg::EXP_ONE : e;
		case (fmt)
			f2p_pkg::FMT_PCM24_IN_32, f2p_pkg::FMT_PCM24: d.scl = f2p_pkg::SCL_24;
			f2p_pkg::FMT_PCM32: d.scl = f2p_pkg::SCL_UNIT;
			default: d.scl = f2p_pkg::SCL_16;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		dec_s1 <= d;
	end
endmodule
`default_nettype wire

@@ sv/f2p_mul.sv @@
// Stage 2: mantissa times full-scale constant.
`default_nettype none
module f2p_mul (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          vld_s1,
	input  wire f2p_pkg::dec_t dec_s1,
	output logic               vld_s2,
	output f2p_pkg::mul_t      mul_s2
);
	logic [22:0] c;

	always_comb begin
		case (dec_s1.scl)
			f2p_pkg::SCL_16: c = f2p_pkg::SCALE_16;
			f2p_pkg::SCL_24: c = f2p_pkg::SCALE_24;
			default:         c = 23'd1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		mul_s2.meta <= dec_s1.meta;
		mul_s2.prod <= 47'(dec_s1.mant) * 47'(c);
		mul_s2.expb <= dec_s1.expb;
		mul_s2.scl  <= dec_s1.scl;
	end
endmodule
`default_nettype wire

@@ sv/f2p_round.sv @@
// Stage 3: round the product to 24 significant bits, nearest even.
`default_nettype none
module f2p_round (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          vld_s2,
	input  wire f2p_pkg::mul_t mul_s2,
	output logic               vld_s3,
	output f2p_pkg::rnd_t      rnd_s3
);
	logic [4:0]  k;
	logic [46:0] kept;
	logic [46:0] rem;
	logic [46:0] half;
	logic        up;
	logic [9:0]  sh;

	always_comb begin
		// leading one sits at one of two known places for a normal input
		case (mul_s2.scl)
			f2p_pkg::SCL_16: k = mul_s2.prod[38] ? 5'd15 : 5'd14;
			f2p_pkg::SCL_24: k = mul_s2.prod[46] ? 5'd23 : 5'd22;
			default:         k = 5'd0;
		endcase
		kept = mul_s2.prod >> k;
		rem  = mul_s2.prod & ((47'd1 << k) - 47'd1);
		half = (k == 5'd0) ? 47'd0 : (47'd1 << (k - 5'd1));
		up   = (k != 5'd0) && ((rem > half) || ((rem == half) && kept[0]));
		sh   = 10'(k) + 10'(mul_s2.expb) - f2p_pkg::EXP_OFS
			+ ((mul_s2.scl == f2p_pkg::SCL_UNIT) ? f2p_pkg::UNIT_SH : 10'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		rnd_s3.meta <= mul_s2.meta;
		rnd_s3.rnd  <= 25'(kept) + 25'(up);
		rnd_s3.sh   <= $signed(sh);
	end
endmodule
`default_nettype wire

@@ sv/f2p_pack.sv @@
// Stage 4: align, truncate toward zero, apply sign and pack the word.
`default_nettype none
module f2p_pack (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          vld_s3,
	input  wire f2p_pkg::rnd_t rnd_s3,
	output logic               vld_s4,
	output f2p_pkg::res_t      res_s4
);
	logic [9:0]    nsh;
	logic [31:0]   mag;
	logic [31:0]   val;
	f2p_pkg::res_t r;

	always_comb begin
		nsh = 10'(-rnd_s3.sh);
		if (rnd_s3.meta.zero) begin
			mag = 32'd0;
		end else if (!rnd_s3.sh[9]) begin
			mag = 32'({7'd0, rnd_s3.rnd} << rnd_s3.sh[3:0]);
		end else if (nsh >= 10'd25) begin
			mag = 32'd0;
		end else begin
			mag = {7'd0, rnd_s3.rnd} >> nsh[4:0];
		end
		// positive full scale of 2^31 saturates
		if (rnd_s3.meta.sign) begin
			val = 32'd0 - mag;
		end else if (mag[31]) begin
			val = 32'h7fffffff;
		end else begin
			val = mag;
		end
		r.last_out = rnd_s3.meta.last;
		case (rnd_s3.meta.fmt)
			f2p_pkg::FMT_FLOAT32: begin
				r.pcm_word   = rnd_s3.meta.raw;
				r.byte_count = 3'd4;
			end
			f2p_pkg::FMT_PCM24_IN_32: begin
				r.pcm_word   = val << 8;
				r.byte_count = 3'd4;
			end
			f2p_pkg::FMT_PCM32: begin
				r.pcm_word   = val;
				r.byte_count = 3'd4;
			end
			f2p_pkg::FMT_PCM24: begin
				r.pcm_word   = {8'd0, val[23:0]};
				r.byte_count = 3'd3;
			end
			default: begin
				r.pcm_word   = {16'd0, val[15:0]};
				r.byte_count = 3'd2;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		res_s4 <= r;
	end
endmodule
`default_nettype wire
